// ===== hdl/tpa_pkg.sv =====
`default_nettype none

package tpa_pkg;

  // coordinate and result formats
  localparam int COORD_BITS     = 16;
  localparam int ROOT_FRAC_BITS = 4;
  localparam int PERIM_W        = 23;
  localparam int AREA_W         = 32;

  // derived widths
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int SUM_SQ_W = SQ_W + 1;
  localparam int ROOT_W   = COORD_BITS + ROOT_FRAC_BITS + 1;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // one input item: three vertices
  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } tpa_in_t;

  // one result item
  typedef struct packed {
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0]  doubled_area;
  } tpa_out_t;

  // edge vectors held in the queue: ab = b - a, bc = c - b, ca = a - c
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx_ab;
    logic signed [DIFF_W-1:0] dy_ab;
    logic signed [DIFF_W-1:0] dx_bc;
    logic signed [DIFF_W-1:0] dy_bc;
    logic signed [DIFF_W-1:0] dx_ca;
    logic signed [DIFF_W-1:0] dy_ca;
  } tpa_diff_t;

endpackage

`default_nettype wire

// ===== hdl/triangle_perimeter_area_core.sv =====
// channel  | ports                      | handshake
// ---------+----------------------------+------------------------------------
// input    | start, busy, vertices      | item taken at edge with start & !busy
// result   | done, result               | one-cycle strobe, no back-pressure
//
// one item per cycle sustained; an item passes the holding register, the
// queue, stages 1 and 2, the 21-stage square root pipeline (one root bit
// per stage, three pipelines side by side) and the output register.
// synchronous active-high reset clears the holding register, queue and
// valid pipeline; no clearing pass is needed.
// the back end never stalls, so busy only rises if the queue ever fills.
`default_nettype none

module triangle_perimeter_area_core import tpa_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire tpa_in_t vertices,
  output logic         busy,
  output logic         done,
  output tpa_out_t     result
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  tpa_diff_t q_wdata;
  tpa_diff_t q_rdata;

  // front: take items and form edge vectors
  tpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .vertices (vertices),
    .q_full   (q_full),
    .busy     (busy),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // queue between front and back
  tpa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back: lengths, perimeter and area
  tpa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

endmodule

`default_nettype wire

// ===== hdl/tpa_front.sv =====
`default_nettype none

module tpa_front import tpa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire tpa_in_t   vertices,
  input  wire logic      q_full,
  output logic           busy,
  output logic           q_push,
  output tpa_diff_t      q_data
);

  logic      f_valid;
  tpa_diff_t diff_next;
  logic      accept;

  // handshake: hold off only when the held item cannot enter the queue
  assign busy   = f_valid && q_full;
  assign q_push = f_valid && !q_full;
  assign accept = start && !busy;

  // edge vectors of the triangle
  always_comb begin
    diff_next.dx_ab = DIFF_W'(vertices.bx)       - DIFF_W'(vertices.ax);
    diff_next.dy_ab = DIFF_W'(vertices.by_coord) - DIFF_W'(vertices.ay);
    diff_next.dx_bc = DIFF_W'(vertices.cx)       - DIFF_W'(vertices.bx);
    diff_next.dy_bc = DIFF_W'(vertices.cy)       - DIFF_W'(vertices.by_coord);
    diff_next.dx_ca = DIFF_W'(vertices.ax)       - DIFF_W'(vertices.cx);
    diff_next.dy_ca = DIFF_W'(vertices.ay)       - DIFF_W'(vertices.cy);
  end

  // holding register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  // holding register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      q_data <= diff_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tpa_queue.sv =====
`default_nettype none

module tpa_queue import tpa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire tpa_diff_t wdata,
  input  wire logic      pop,
  output logic           full,
  output logic           empty,
  output tpa_diff_t      rdata
);

  tpa_diff_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // no write into a full queue
  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue overflow");

  // no read from an empty queue
  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue underflow");

  // fill count agrees with the pointer distance
  assert property (@(posedge clk) disable iff (rst)
    (count == QCNT_W'(QUEUE_DEPTH)) || (QPTR_W'(wptr - rptr) == count[QPTR_W-1:0]))
    else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

// ===== hdl/tpa_sqrt.sv =====
`default_nettype none

module tpa_sqrt import tpa_pkg::*; (
  input  wire logic             clk,
  input  wire logic [RAD_W-1:0] rad,
  output logic      [ROOT_W-1:0] root
);

  logic [ROOT_W-1:0] root_q    [ROOT_W];
  logic [REM_W-1:0]  rem_q     [ROOT_W];
  logic [RAD_W-1:0]  rad_q     [ROOT_W];
  logic [ROOT_W-1:0] root_prev [ROOT_W];
  logic [REM_W-1:0]  rem_prev  [ROOT_W];
  logic [RAD_W-1:0]  rad_prev  [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];
  logic [REM_W-1:0]  rem_next  [ROOT_W];
  logic [RAD_W-1:0]  rad_next  [ROOT_W];

  // stage inputs: the first stage starts from an empty root
  always_comb begin
    root_prev[0] = '0;
    rem_prev[0]  = '0;
    rad_prev[0]  = rad;
    for (int i = 1; i < ROOT_W; i++) begin
      root_prev[i] = root_q[i-1];
      rem_prev[i]  = rem_q[i-1];
      rad_prev[i]  = rad_q[i-1];
    end
  end

  // one root bit per stage, restoring form
  always_comb begin
    for (int i = 0; i < ROOT_W; i++) begin
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      rem_sh = {rem_prev[i][REM_W-3:0], rad_prev[i][RAD_W-1 -: 2]};
      trial  = {root_prev[i], 2'b01};
      rad_next[i] = rad_prev[i] << 2;
      if (rem_sh >= trial) begin
        root_next[i] = {root_prev[i][ROOT_W-2:0], 1'b1};
        rem_next[i]  = rem_sh - trial;
      end else begin
        root_next[i] = {root_prev[i][ROOT_W-2:0], 1'b0};
        rem_next[i]  = rem_sh;
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < ROOT_W; i++) begin
      root_q[i] <= root_next[i];
      rem_q[i]  <= rem_next[i];
      rad_q[i]  <= rad_next[i];
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hdl/tpa_back.sv =====
`default_nettype none

module tpa_back import tpa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_empty,
  input  wire tpa_diff_t q_data,
  output logic           q_pop,
  output logic           done,
  output tpa_out_t       result
);

  localparam int PSUM_W = ROOT_W + 2;

  function automatic logic [COORD_BITS-1:0] mag(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = d[DIFF_W-1] ? -d : d;
    return n[COORD_BITS-1:0];
  endfunction

  logic                      s1_valid;
  logic [SQ_W-1:0]           sq_ab_x, sq_ab_y, sq_bc_x, sq_bc_y, sq_ca_x, sq_ca_y;
  logic signed [PROD_W-1:0]  prod_p, prod_n;
  logic                      s2_valid;
  logic [RAD_W-1:0]          rad_ab, rad_bc, rad_ca;
  logic [AREA_W-1:0]         s2_area;
  logic signed [CROSS_W-1:0] cross_sum;
  logic signed [CROSS_W-1:0] cross_abs;
  logic [ROOT_W-1:0]         len_ab, len_bc, len_ca;
  logic [ROOT_W-1:0]         vld_line;
  logic [AREA_W-1:0]         area_line [ROOT_W];
  logic [PSUM_W-1:0]         perim_sum;

  // the back end never stalls: take an item whenever one waits
  assign q_pop = !q_empty;

  // stage 1: squares and cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    sq_ab_x <= mag(q_data.dx_ab) * mag(q_data.dx_ab);
    sq_ab_y <= mag(q_data.dy_ab) * mag(q_data.dy_ab);
    sq_bc_x <= mag(q_data.dx_bc) * mag(q_data.dx_bc);
    sq_bc_y <= mag(q_data.dy_bc) * mag(q_data.dy_bc);
    sq_ca_x <= mag(q_data.dx_ca) * mag(q_data.dx_ca);
    sq_ca_y <= mag(q_data.dy_ca) * mag(q_data.dy_ca);
    prod_p  <= q_data.dy_ab * q_data.dx_ca;
    prod_n  <= q_data.dx_ab * q_data.dy_ca;
  end

  // stage 2: radicands and area magnitude
  assign cross_sum = CROSS_W'(prod_p) - CROSS_W'(prod_n);
  assign cross_abs = cross_sum[CROSS_W-1] ? -cross_sum : cross_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    rad_ab  <= RAD_W'(SUM_SQ_W'(sq_ab_x) + SUM_SQ_W'(sq_ab_y)) << (2 * ROOT_FRAC_BITS);
    rad_bc  <= RAD_W'(SUM_SQ_W'(sq_bc_x) + SUM_SQ_W'(sq_bc_y)) << (2 * ROOT_FRAC_BITS);
    rad_ca  <= RAD_W'(SUM_SQ_W'(sq_ca_x) + SUM_SQ_W'(sq_ca_y)) << (2 * ROOT_FRAC_BITS);
    s2_area <= AREA_W'(cross_abs);
  end

  // edge lengths
  tpa_sqrt u_sqrt_ab (.clk(clk), .rad(rad_ab), .root(len_ab));
  tpa_sqrt u_sqrt_bc (.clk(clk), .rad(rad_bc), .root(len_bc));
  tpa_sqrt u_sqrt_ca (.clk(clk), .rad(rad_ca), .root(len_ca));

  // valid and area ride alongside the root pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_line <= '0;
    end else begin
      vld_line <= {vld_line[ROOT_W-2:0], s2_valid};
    end
  end

  always_ff @(posedge clk) begin
    area_line[0] <= s2_area;
    for (int i = 1; i < ROOT_W; i++) begin
      area_line[i] <= area_line[i-1];
    end
  end

  // perimeter and output register
  assign perim_sum = PSUM_W'(len_ab) + PSUM_W'(len_bc) + PSUM_W'(len_ca);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_line[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    result.perimeter    <= PERIM_W'(perim_sum);
    result.doubled_area <= area_line[ROOT_W-1];
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_triangle_perimeter_area_core.sv =====
`timescale 1ns / 1ps

module tb_triangle_perimeter_area_core;
  import tpa_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 1400;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  tpa_in_t  vertices = '0;
  logic     busy;
  logic     done;
  tpa_out_t result;

  tpa_in_t  tri_pending[$];
  tpa_out_t measures_due[$];
  int       mismatch_count = 0;
  int       taken_count = 0;
  int       drain_point_a = 0;
  int       drain_point_b = 0;
  bit       drain_hold = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       idle_cycles = 0;

  triangle_perimeter_area_core DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .vertices (vertices),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always #10 clk = ~clk;

  // floor square root, bit by bit
  function automatic longint unsigned floor_root(longint unsigned rad);
    longint unsigned root;
    longint unsigned trial;
    int b;
    root = 0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    return root;
  endfunction

  // edge length with ROOT_FRAC_BITS fraction bits, floored
  function automatic longint unsigned edge_length(longint x0, longint y0,
                                                  longint x1, longint y1);
    longint dx;
    longint dy;
    longint unsigned sum_sq;
    dx = x1 - x0;
    dy = y1 - y0;
    sum_sq = longint'(dx * dx + dy * dy);
    return floor_root(sum_sq << (2 * ROOT_FRAC_BITS));
  endfunction

  // perimeter and doubled shoelace area of one triangle
  function automatic tpa_out_t triangle_measures(tpa_in_t v);
    longint ax, ay, bx, by, cx, cy;
    longint cross_sum;
    longint unsigned perim;
    tpa_out_t r;
    ax = $signed(v.ax);
    ay = $signed(v.ay);
    bx = $signed(v.bx);
    by = $signed(v.by_coord);
    cx = $signed(v.cx);
    cy = $signed(v.cy);
    perim = edge_length(ax, ay, bx, by) + edge_length(bx, by, cx, cy)
          + edge_length(cx, cy, ax, ay);
    cross_sum = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    if (cross_sum < 0) cross_sum = -cross_sum;
    r.perimeter    = PERIM_W'(perim);
    r.doubled_area = AREA_W'(cross_sum);
    return r;
  endfunction

  function automatic void queue_triangle(int ax, int ay, int bx, int by, int cx, int cy);
    tpa_in_t v;
    v.ax       = COORD_BITS'(ax);
    v.ay       = COORD_BITS'(ay);
    v.bx       = COORD_BITS'(bx);
    v.by_coord = COORD_BITS'(by);
    v.cx       = COORD_BITS'(cx);
    v.cy       = COORD_BITS'(cy);
    tri_pending.push_back(v);
  endfunction

  // coordinate drawn mostly from the corners of the range
  function automatic int corner_coord();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // stimulus: directed triangles, then random ones
  initial begin
    int i, k, ox, oy, dx, dy;
    // all vertices at one point
    queue_triangle(0, 0, 0, 0, 0, 0);
    queue_triangle(32767, 32767, 32767, 32767, 32767, 32767);
    queue_triangle(-32768, -32768, -32768, -32768, -32768, -32768);
    // largest right triangles, both orientations
    queue_triangle(-32768, -32768, 32767, -32768, 32767, 32767);
    queue_triangle(-32768, -32768, 32767, 32767, 32767, -32768);
    queue_triangle(-32768, 32767, 32767, -32768, 32767, 32767);
    queue_triangle(-32768, -32768, 32767, 32767, -32768, 32767);
    // exact edge lengths
    queue_triangle(0, 0, 3, 0, 0, 4);
    queue_triangle(0, 0, 0, 4, 3, 0);
    queue_triangle(-5, -12, 0, 0, -5, 0);
    // edges with fractional roots
    queue_triangle(0, 0, 1, 1, 2, 0);
    queue_triangle(0, 0, 1, 0, 0, 1);
    queue_triangle(-1, -1, 0, 0, 1, -1);
    // degenerate: collinear and coincident
    queue_triangle(-32768, -32768, 0, 0, 32767, 32767);
    queue_triangle(-100, 50, 0, 0, 100, -50);
    queue_triangle(7, 7, 7, 7, 100, -300);
    queue_triangle(-32768, 0, 32767, 0, 0, 0);
    queue_triangle(0, -32768, 0, 32767, 0, 12345);
    // one-bit steps and sign boundary
    queue_triangle(-1, 0, 0, -1, 0, 0);
    queue_triangle(32767, -32768, -32768, 32767, 32767, 32767);
    queue_triangle(-32768, 32767, 32767, -32768, -32768, -32768);
    drain_point_a = tri_pending.size();
    drain_point_b = drain_point_a + RANDOM_ITEMS / 2;

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          queue_triangle(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                         int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                         int'($signed(16'($urandom))), int'($signed(16'($urandom))));
        6, 7: begin
          // small triangle around a random center
          ox = int'($signed(16'($urandom)));
          oy = int'($signed(16'($urandom)));
          queue_triangle(ox + $urandom_range(0, 30) - 15, oy + $urandom_range(0, 30) - 15,
                         ox + $urandom_range(0, 30) - 15, oy + $urandom_range(0, 30) - 15,
                         ox + $urandom_range(0, 30) - 15, oy + $urandom_range(0, 30) - 15);
        end
        8: begin
          // collinear vertices
          ox = int'($signed(16'($urandom)));
          oy = int'($signed(16'($urandom)));
          dx = $urandom_range(0, 600) - 300;
          dy = $urandom_range(0, 600) - 300;
          k  = $urandom_range(0, 100) - 50;
          queue_triangle(ox, oy, ox + dx, oy + dy, ox + k * dx, oy + k * dy);
        end
        default:
          queue_triangle(corner_coord(), corner_coord(), corner_coord(),
                         corner_coord(), corner_coord(), corner_coord());
      endcase
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (tri_pending.size() != 0 || measures_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_triangle_perimeter_area_core: done, clean");
    end else begin
      $display("tb_triangle_perimeter_area_core: done, errors");
    end
    $finish;
  end

  // driver: bursts of items with random gaps, one drain pause per point
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        measures_due.push_back(triangle_measures(vertices));
        void'(tri_pending.pop_front());
        taken_count++;
        if (taken_count == drain_point_a || taken_count == drain_point_b) drain_hold = 1'b1;
      end
      if (start && busy) begin
        // item still offered, hold it
      end else if (drain_hold) begin
        if (measures_due.size() == 0) drain_hold = 1'b0;
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (tri_pending.size() != 0) begin
        vertices <= tri_pending[0];
        start    <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest expected one
  always @(posedge clk) begin
    tpa_out_t want;
    if (!rst && done) begin
      if (measures_due.size() == 0) begin
        flag_mismatch("unexpected result, perimeter", result.perimeter, 0);
      end else begin
        want = measures_due.pop_front();
        if (result.perimeter !== want.perimeter)
          flag_mismatch("perimeter", result.perimeter, want.perimeter);
        if (result.doubled_area !== want.doubled_area)
          flag_mismatch("doubled_area", result.doubled_area, want.doubled_area);
      end
    end
  end

  // watchdog: too long with neither an item taken nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $realtime, measures_due.size());
      $display("tb_triangle_perimeter_area_core: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
